[sv/bhsf_pkg.sv]
// Shared constants and widths for the bitmap horizontal span fill block.
`default_nettype none
package bhsf_pkg;
   localparam int STORE_BYTES   = 4096;
   localparam int MAX_ROW_BYTES = 128;
   localparam int ADDR_W        = $clog2(STORE_BYTES);
   // Wide enough for row * row_bytes + last byte at the largest settings.
   localparam int SUM_W         = 24;

   localparam int KIND_W  = 1;
   localparam int X_W     = 10;
   localparam int ROW_W   = 12;
   localparam int RADDR_W = 12;
   localparam int DATA_W  = 8;
   localparam int RB_W    = 8;

   localparam logic [KIND_W-1:0] KIND_DRAW = 1'b0;
   localparam logic [KIND_W-1:0] KIND_READ = 1'b1;

   localparam logic STATUS_DONE   = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   localparam logic [DATA_W-1:0] FULL_BYTE  = 8'hFF;
   localparam logic [RB_W-1:0]   RB_RESET   = 8'd4;
endpackage
`default_nettype wire

[sv/bhsf_if.sv]
// Valid/ready channel interfaces for span requests and their responses.
`default_nettype none
interface bhsf_req_if;
   logic                         valid;
   logic                         ready;
   logic [bhsf_pkg::KIND_W-1:0]  kind;
   logic [bhsf_pkg::X_W-1:0]     x_start;
   logic [bhsf_pkg::X_W-1:0]     x_end;
   logic [bhsf_pkg::ROW_W-1:0]   row;
   logic [bhsf_pkg::RADDR_W-1:0] read_addr;

   modport source (output valid, kind, x_start, x_end, row, read_addr, input ready);
   modport sink (input valid, kind, x_start, x_end, row, read_addr, output ready);
endinterface

interface bhsf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bhsf_pkg::DATA_W-1:0] read_data;
   logic                        status;

   modport source (output valid, read_data, status, input ready);
   modport sink (input valid, read_data, status, output ready);
endinterface
`default_nettype wire

[sv/bitmap_horizontal_span_fill_core.sv]
// Top level of the one-bit-per-pixel framebuffer with horizontal span fill.
//
//   channel | direction | handshake     | payload
//   req_bus | in        | valid/ready   | kind, x_start, x_end, row, read_addr
//   rsp_bus | out       | valid/ready   | read_data, status
//   csr     | in        | csr_wr_en     | csr_wr_data (row_bytes)
//
// A read item is range-checked, then read. A draw whose ends share one byte writes only
// that byte; a wider draw writes its first byte, each inner byte, then its last byte, as
// the single frame store port writes one byte per cycle. A rejected draw writes nothing.
// After reset a clearing pass writes zero to all STORE_BYTES (4096) bytes, one per
// cycle, and req_bus.ready stays low until it finishes. A stalled response holds in
// its output register while the next item is taken and worked on.
`default_nettype none
module bitmap_horizontal_span_fill_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   bhsf_req_if.sink                         req_bus,
   bhsf_rsp_if.source                       rsp_bus,
   input  wire logic                        csr_wr_en,
   input  wire logic [bhsf_pkg::RB_W-1:0]   csr_wr_data
);
   localparam int AW = bhsf_pkg::ADDR_W;
   localparam int SW = bhsf_pkg::SUM_W;

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_MUL      = 4'd2;
   localparam logic [3:0] S_RANGE    = 4'd3;
   localparam logic [3:0] S_RD_FIRST = 4'd4;
   localparam logic [3:0] S_WR_FIRST = 4'd5;
   localparam logic [3:0] S_FILL     = 4'd6;
   localparam logic [3:0] S_WR_LAST  = 4'd7;
   localparam logic [3:0] S_RD_BYTE  = 4'd8;
   localparam logic [3:0] S_RD_DATA  = 4'd9;
   localparam logic [3:0] S_DONE     = 4'd10;

   logic [3:0]                        state_ff, state_in;
   logic [AW-1:0]                     clr_ff, clr_in;
   logic [bhsf_pkg::RB_W-1:0]         row_bytes_ff, row_bytes_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   logic [bhsf_pkg::X_W-1:0]          xs_ff, xs_in, xe_ff, xe_in;
   logic [bhsf_pkg::ROW_W-1:0]        row_ff, row_in;
   logic [bhsf_pkg::RADDR_W-1:0]      raddr_ff, raddr_in;
   logic [SW-1:0]                     base_ff, base_in;
   logic [AW-1:0]                     cur_ff, cur_in, end_ff, end_in;
   logic [bhsf_pkg::DATA_W-1:0]       res_data_ff, res_data_in;
   logic                              res_status_ff, res_status_in;
   logic [bhsf_pkg::DATA_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                              rsp_status_ff, rsp_status_in;

   logic                              req_fire;
   logic                              slot_free;
   logic [bhsf_pkg::X_W-4:0]          first_byte, last_byte;
   logic [7:0]                        smask, emask, first_mask;
   logic [SW-1:0]                     last_sum, first_sum, raddr_ext;
   logic                              rb_bad;

   logic                              mem_we;
   logic [AW-1:0]                     mem_wr_addr, mem_rd_addr;
   logic [bhsf_pkg::DATA_W-1:0]       mem_wr_data, mem_rd_data;

   bhsf_ram #(
      .WIDTH (bhsf_pkg::DATA_W),
      .DEPTH (bhsf_pkg::STORE_BYTES)
   ) u_frame_store (
      .clock   (clock),
      .we      (mem_we),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign req_bus.ready     = (state_ff == S_IDLE);
   assign req_fire          = req_bus.valid && req_bus.ready;
   assign slot_free         = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.read_data = rsp_data_ff;
   assign rsp_bus.status    = rsp_status_ff;

   assign first_byte = xs_ff[bhsf_pkg::X_W-1:3];
   assign last_byte  = xe_ff[bhsf_pkg::X_W-1:3];
   assign smask      = 8'hFF >> {1'b0, xs_ff[2:0]};
   // The end offset plus one can reach eight, which shifts every bit out.
   assign emask      = ~(8'hFF >> ({1'b0, xe_ff[2:0]} + 4'd1));
   assign first_mask = (first_byte == last_byte) ? (smask & emask) : smask;
   assign rb_bad     = (row_bytes_ff == '0) ||
                       (SW'(row_bytes_ff) > SW'(bhsf_pkg::MAX_ROW_BYTES));
   assign last_sum   = base_ff + SW'(last_byte);
   assign first_sum  = base_ff + SW'(first_byte);
   assign raddr_ext  = SW'(raddr_ff);

   always_comb begin
      mem_we      = 1'b0;
      mem_wr_addr = cur_ff;
      mem_wr_data = mem_rd_data | first_mask;
      mem_rd_addr = cur_ff;
      unique case (state_ff)
         S_CLEAR: begin
            mem_we      = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
         end
         S_WR_FIRST: begin
            mem_we = 1'b1;
         end
         S_FILL: begin
            mem_rd_addr = end_ff;
            mem_we      = (cur_ff != end_ff);
            mem_wr_data = bhsf_pkg::FULL_BYTE;
         end
         S_WR_LAST: begin
            mem_we      = 1'b1;
            mem_wr_addr = end_ff;
            mem_wr_data = mem_rd_data | emask;
         end
         S_RD_BYTE: begin
            mem_rd_addr = raddr_ext[AW-1:0];
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      row_bytes_in  = csr_wr_en ? csr_wr_data : row_bytes_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      xs_in         = xs_ff;
      xe_in         = xe_ff;
      row_in        = row_ff;
      raddr_in      = raddr_ff;
      base_in       = base_ff;
      cur_in        = cur_ff;
      end_in        = end_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(bhsf_pkg::STORE_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               xs_in       = req_bus.x_start;
               xe_in       = req_bus.x_end;
               row_in      = req_bus.row;
               raddr_in    = req_bus.read_addr;
               res_data_in = '0;
               state_in    = (req_bus.kind == bhsf_pkg::KIND_READ) ? S_RD_BYTE : S_MUL;
            end
         end
         S_MUL: begin
            base_in = SW'(row_ff * row_bytes_ff);
            if (rb_bad || (xs_ff > xe_ff) || (SW'(last_byte) >= SW'(row_bytes_ff))) begin
               res_status_in = bhsf_pkg::STATUS_REJECT;
               state_in      = S_DONE;
            end else begin
               state_in = S_RANGE;
            end
         end
         S_RANGE: begin
            cur_in = first_sum[AW-1:0];
            end_in = last_sum[AW-1:0];
            if (last_sum >= SW'(bhsf_pkg::STORE_BYTES)) begin
               res_status_in = bhsf_pkg::STATUS_REJECT;
               state_in      = S_DONE;
            end else begin
               state_in = S_RD_FIRST;
            end
         end
         S_RD_FIRST: begin
            state_in = S_WR_FIRST;
         end
         S_WR_FIRST: begin
            cur_in = cur_ff + 1'b1;
            if (cur_ff == end_ff) begin
               res_status_in = bhsf_pkg::STATUS_DONE;
               state_in      = S_DONE;
            end else begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            // The read of the last byte is issued every cycle here, so its data
            // is ready as soon as the run of full bytes reaches the end.
            if (cur_ff == end_ff) begin
               state_in = S_WR_LAST;
            end else begin
               cur_in = cur_ff + 1'b1;
            end
         end
         S_WR_LAST: begin
            res_status_in = bhsf_pkg::STATUS_DONE;
            state_in      = S_DONE;
         end
         S_RD_BYTE: begin
            if (raddr_ext < SW'(bhsf_pkg::STORE_BYTES)) begin
               state_in = S_RD_DATA;
            end else begin
               res_status_in = bhsf_pkg::STATUS_REJECT;
               state_in      = S_DONE;
            end
         end
         S_RD_DATA: begin
            res_data_in   = mem_rd_data;
            res_status_in = bhsf_pkg::STATUS_DONE;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = res_data_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         row_bytes_ff <= bhsf_pkg::RB_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         row_bytes_ff <= row_bytes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      xs_ff         <= xs_in;
      xe_ff         <= xe_in;
      row_ff        <= row_in;
      raddr_ff      <= raddr_in;
      base_ff       <= base_in;
      cur_ff        <= cur_in;
      end_ff        <= end_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

`ifndef SYNTHESIS
   // No item is taken while the store is still being cleared.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_bus.ready)
      else $error("request accepted during clearing pass");

   // An accepted item always starts work in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != S_IDLE))
      else $error("accepted item was dropped");

   // Full-byte writes stay strictly before the last byte of the span.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL && mem_we) |-> (cur_ff < end_ff))
      else $error("fill wrote past the end of the span");

   // A pending result is only moved out when the output register is free.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && !rsp_bus.ready) |=> (state_ff == S_DONE))
      else $error("result overwrote a stalled response");
`endif
endmodule
`default_nettype wire

[sv/bhsf_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module bhsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[bench/span_fill_checker.sv]
// Scoreboard that mirrors the frame store and checks every response of the span fill core.
`timescale 1ns / 100ps
module span_fill_checker (
   input  wire logic                      clock,
   input  wire logic                      reset,
   bhsf_req_if                            req_bus,
   bhsf_rsp_if                            rsp_bus,
   input  wire logic                      csr_wr_en,
   input  wire logic [bhsf_pkg::RB_W-1:0] csr_wr_data,
   output int                             mismatches,
   output int                             outstanding
);
   localparam int AW = bhsf_pkg::ADDR_W;

   typedef struct packed {
      logic [bhsf_pkg::DATA_W-1:0] read_data;
      logic                        status;
   } span_response_type;

   logic [bhsf_pkg::DATA_W-1:0] shadow_bytes [bhsf_pkg::STORE_BYTES];
   int unsigned                 row_width;
   span_response_type           owed_responses [$];
   int                          error_count = 0;

   // Updates the shadow store for one item and returns the response it must produce.
   function automatic span_response_type apply_span_item(
      input logic [bhsf_pkg::KIND_W-1:0]  kind,
      input logic [bhsf_pkg::X_W-1:0]     xs,
      input logic [bhsf_pkg::X_W-1:0]     xe,
      input logic [bhsf_pkg::ROW_W-1:0]   row,
      input logic [bhsf_pkg::RADDR_W-1:0] addr);
      span_response_type resp;
      int unsigned       first_byte;
      int unsigned       last_byte;
      int unsigned       base;
      int unsigned       head_mask;
      int unsigned       tail_mask;
      int unsigned       mask;
      int unsigned       col;
      resp.read_data = '0;
      resp.status    = bhsf_pkg::STATUS_DONE;
      if (kind == bhsf_pkg::KIND_READ) begin
         if (int'(addr) < bhsf_pkg::STORE_BYTES) begin
            resp.read_data = shadow_bytes[addr];
         end else begin
            resp.status = bhsf_pkg::STATUS_REJECT;
         end
         return resp;
      end
      first_byte = xs / 8;
      last_byte  = xe / 8;
      base       = row * row_width;
      if (row_width == 0 || row_width > bhsf_pkg::MAX_ROW_BYTES || xs > xe ||
          last_byte >= row_width || base + last_byte >= bhsf_pkg::STORE_BYTES) begin
         resp.status = bhsf_pkg::STATUS_REJECT;
         return resp;
      end
      // Leftmost pixel is the MSB, so the head keeps low bits and the tail high bits.
      head_mask = 32'hFF >> (xs % 8);
      tail_mask = 32'hFF & ~(32'hFF >> (xe % 8 + 1));
      for (col = first_byte; col <= last_byte; col++) begin
         mask = 32'hFF;
         if (col == first_byte) mask &= head_mask;
         if (col == last_byte) mask &= tail_mask;
         shadow_bytes[AW'(base + col)] |= mask[bhsf_pkg::DATA_W-1:0];
      end
      return resp;
   endfunction

   always @(posedge clock) begin
      span_response_type want;
      if (reset) begin
         foreach (shadow_bytes[i]) shadow_bytes[i] = '0;
         row_width = 32'(bhsf_pkg::RB_RESET);
         owed_responses.delete();
         error_count = 0;
      end else begin
         if (csr_wr_en) row_width = 32'(csr_wr_data);
         if (req_bus.valid && req_bus.ready) begin
            owed_responses.push_back(apply_span_item(req_bus.kind, req_bus.x_start,
                                                     req_bus.x_end, req_bus.row,
                                                     req_bus.read_addr));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (owed_responses.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual read_data %02h status %0d",
                        $time, rsp_bus.read_data, rsp_bus.status);
               error_count++;
            end else begin
               want = owed_responses.pop_front();
               if (rsp_bus.read_data !== want.read_data) begin
                  $display("%0t: read_data mismatch, expected %02h, actual %02h",
                           $time, want.read_data, rsp_bus.read_data);
                  error_count++;
               end
               if (rsp_bus.status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want.status, rsp_bus.status);
                  error_count++;
               end
            end
         end
      end
      mismatches  <= error_count;
      outstanding <= owed_responses.size();
   end
endmodule

[bench/testbench.sv]
// Top of the span fill regression: clock, reset, stimulus, back-pressure and the verdict.
`timescale 1ns / 100ps
module testbench;
   localparam int CYCLE_LIMIT        = 2_000_000;
   localparam int HOLD_CYCLES        = 300;
   localparam int TAIL_CYCLES        = 200;
   localparam int RANDOM_PER_SETTING = 108;
   localparam int BURST_ITEMS        = 24;

   localparam int XW   = bhsf_pkg::X_W;
   localparam int ROWW = bhsf_pkg::ROW_W;
   localparam int RAW  = bhsf_pkg::RADDR_W;

   logic                      clock;
   logic                      reset;
   logic                      csr_wr_en;
   logic [bhsf_pkg::RB_W-1:0] csr_wr_data;
   int                        req_gap_pct;
   int                        rsp_stall_pct;
   logic                      hold_toggle;
   logic                      hold_seen;
   int                        hold_left;
   int                        mismatches;
   int                        responses_owed;
   int                        cycle_count = 0;

   bhsf_req_if req_bus ();
   bhsf_rsp_if rsp_bus ();

   bitmap_horizontal_span_fill_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   span_fill_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mismatches  (mismatches),
      .outstanding (responses_owed)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bitmap_horizontal_span_fill_core regression: fail");
         $finish;
      end
   end

   // Response side: random stalls, plus one long hold-off whenever hold_toggle flips.
   initial begin
      rsp_bus.ready <= 1'b0;
      hold_seen = 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   task automatic send_item(input logic [bhsf_pkg::KIND_W-1:0] kind,
                            input int unsigned                 xs,
                            input int unsigned                 xe,
                            input int unsigned                 row,
                            input int unsigned                 addr);
      while ($urandom_range(99) < req_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.kind      <= kind;
      req_bus.x_start   <= XW'(xs);
      req_bus.x_end     <= XW'(xe);
      req_bus.row       <= ROWW'(row);
      req_bus.read_addr <= RAW'(addr);
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // The owed count is registered in the checker, so look at it only once the checker has updated it.
   task automatic wait_all_answered();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (responses_owed != 0);
   endtask

   task automatic write_row_bytes(input logic [bhsf_pkg::RB_W-1:0] value);
      wait_all_answered();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly in-row spans and reads near the painted rows; the rest is raw noise.
   task automatic send_random_item(input int unsigned width);
      int unsigned xs;
      int unsigned xe;
      int unsigned row;
      int unsigned addr;
      int unsigned pick;
      int unsigned rows_fit;
      int unsigned read_span;
      pick = $urandom_range(99);
      xs   = $urandom_range((1 << XW) - 1);
      xe   = $urandom_range((1 << XW) - 1);
      row  = $urandom_range((1 << ROWW) - 1);
      addr = $urandom_range((1 << RAW) - 1);
      if (width >= 1 && width <= bhsf_pkg::MAX_ROW_BYTES && pick < 85) begin
         rows_fit = bhsf_pkg::STORE_BYTES / width;
         if (pick < 35) begin
            read_span = (64 * width < bhsf_pkg::STORE_BYTES) ? 64 * width :
                                                               bhsf_pkg::STORE_BYTES;
            addr = $urandom_range(read_span - 1, 0);
            send_item(bhsf_pkg::KIND_READ, xs, xe, row, addr);
         end else begin
            xs = $urandom_range(width * 8 - 1, 0);
            xe = $urandom_range(width * 8 - 1, xs);
            if ($urandom_range(3) == 0) begin
               row = $urandom_range(rows_fit - 1, 0);
            end else begin
               row = $urandom_range((rows_fit < 64) ? rows_fit : 64, 0);
            end
            send_item(bhsf_pkg::KIND_DRAW, xs, xe, row, addr);
         end
      end else begin
         send_item($urandom_range(1) ? bhsf_pkg::KIND_READ : bhsf_pkg::KIND_DRAW,
                   xs, xe, row, addr);
      end
   endtask

   initial begin
      int unsigned width_plan [12] = '{1, 128, 4, 0, 37, 255, 16, 129, 2, 100, 8, 64};
      int unsigned width;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.kind      <= bhsf_pkg::KIND_DRAW;
      req_bus.x_start   <= '0;
      req_bus.x_end     <= '0;
      req_bus.row       <= '0;
      req_bus.read_addr <= '0;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      hold_toggle       <= 1'b0;
      req_gap_pct       <= 32;
      rsp_stall_pct     <= 76;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset row width of four bytes.
      send_item(bhsf_pkg::KIND_READ, 0, 0, 0, 0);
      send_item(bhsf_pkg::KIND_READ, 1023, 0, 4095, 4095);
      send_item(bhsf_pkg::KIND_DRAW, 3, 5, 0, 4095);       // both ends in one byte
      send_item(bhsf_pkg::KIND_READ, 0, 0, 0, 0);
      send_item(bhsf_pkg::KIND_DRAW, 0, 31, 1, 0);         // whole row, full middle bytes
      send_item(bhsf_pkg::KIND_DRAW, 9, 22, 2, 0);         // adjacent end bytes
      send_item(bhsf_pkg::KIND_READ, 0, 0, 0, 9);
      send_item(bhsf_pkg::KIND_DRAW, 10, 9, 0, 0);         // reversed span
      send_item(bhsf_pkg::KIND_DRAW, 0, 32, 0, 0);         // one byte past the row
      send_item(bhsf_pkg::KIND_DRAW, 1023, 1023, 0, 0);
      send_item(bhsf_pkg::KIND_DRAW, 0, 31, 1023, 0);      // last row that fits the store
      send_item(bhsf_pkg::KIND_DRAW, 0, 0, 1024, 0);       // first row past the store
      send_item(bhsf_pkg::KIND_DRAW, 0, 0, 4095, 0);
      send_item(bhsf_pkg::KIND_READ, 0, 0, 0, 4095);
      send_item(bhsf_pkg::KIND_DRAW, 7, 7, 3, 0);
      send_item(bhsf_pkg::KIND_DRAW, 0, 0, 3, 0);
      send_item(bhsf_pkg::KIND_READ, 0, 0, 0, 12);
      write_row_bytes(8'd0);                               // zero width rejects every draw
      send_item(bhsf_pkg::KIND_DRAW, 0, 7, 0, 0);
      send_item(bhsf_pkg::KIND_READ, 0, 0, 0, 4);
      write_row_bytes(8'd255);
      send_item(bhsf_pkg::KIND_DRAW, 0, 7, 0, 0);
      write_row_bytes(8'd128);
      send_item(bhsf_pkg::KIND_DRAW, 0, 1023, 31, 0);
      send_item(bhsf_pkg::KIND_DRAW, 0, 1023, 32, 0);
      write_row_bytes(8'd1);
      send_item(bhsf_pkg::KIND_DRAW, 0, 7, 4095, 0);
      send_item(bhsf_pkg::KIND_DRAW, 0, 8, 0, 0);
      send_item(bhsf_pkg::KIND_READ, 0, 0, 0, 3968);

      for (int phase = 0; phase < 3; phase++) begin
         req_gap_pct   <= (phase == 0) ? 32 : (phase == 1) ? 76 : 0;
         rsp_stall_pct <= (phase == 0) ? 76 : (phase == 1) ? 32 : 0;
         for (int k = 0; k < 4; k++) begin
            width = width_plan[phase * 4 + k];
            write_row_bytes(width[bhsf_pkg::RB_W-1:0]);
            if (phase == 2 && k == 0) begin
               // Stall the response side long enough that the core backs up its input.
               hold_toggle <= ~hold_toggle;
               repeat (BURST_ITEMS) send_random_item(width);
               wait_all_answered();
            end
            repeat (RANDOM_PER_SETTING) send_random_item(width);
         end
      end

      wait_all_answered();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && responses_owed == 0) begin
         $display("bitmap_horizontal_span_fill_core regression: pass");
      end else begin
         $display("bitmap_horizontal_span_fill_core regression: fail");
      end
      $finish;
   end
endmodule
